// ===== design/jss_pkg.sv =====
// Shared types and constants for the Jacobi stencil sweep unit.
// Used by the front, back and top level; depends on nothing.
package jss_pkg;

   // Cell values are unsigned Q8.16
   localparam int VALUE_W    = 24;
   localparam int SUM_W      = VALUE_W + 2;
   localparam int WORD_W     = 2 * VALUE_W;
   localparam int DIM_W      = 10;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 24;

   // Register indexes on the csr port
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_WIDTH       = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_HEIGHT      = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CHANGE_THRESHOLD = 2'd2;

   // Register values after reset
   localparam logic [DIM_W-1:0]   RESET_GRID_WIDTH       = 10'd500;
   localparam logic [DIM_W-1:0]   RESET_GRID_HEIGHT      = 10'd500;
   localparam logic [VALUE_W-1:0] RESET_CHANGE_THRESHOLD = 24'd66;

   typedef logic [VALUE_W-1:0] value_type;

   // One classified input beat, handed from front to back
   typedef struct packed {
      value_type value;      // input cell, the lower neighbor of the output cell
      logic      interior;   // output cell gets the stencil
      logic      emit;       // output cell exists (not the first row)
      logic      second;     // last row: input cell itself follows
      logic      frame_end;  // final input of the sweep
   } cmd_type;

   // One result beat
   typedef struct packed {
      value_type new_value;
      logic      frame_last;
      value_type max_change;
      logic      converged;
   } rsp_type;

endpackage

// ===== design/jss_ram.sv =====
// Generic RAM: one write port, two read ports, registered read data.
// Read returns the old contents when read and write hit the same address.
module jss_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 512
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_a,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_a_ff;
   logic [WIDTH-1:0] rd_data_b_ff;

   // Write and registered reads
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_a_ff <= mem_ff[rd_addr_a];
      rd_data_b_ff <= mem_ff[rd_addr_b];
   end

   assign rd_data_a = rd_data_a_ff;
   assign rd_data_b = rd_data_b_ff;

endmodule

// ===== design/jss_fifo.sv =====
// Small register FIFO with one pop and up to two pushes per cycle.
// Self-contained; DEPTH must be a power of two, at least 2.
module jss_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push0,
   input  logic                       push1,
   input  logic [WIDTH-1:0]           data0,
   input  logic [WIDTH-1:0]           data1,
   input  logic                       pop,
   output logic [WIDTH-1:0]           head,
   output logic                       empty,
   output logic [$clog2(DEPTH+1)-1:0] count
);

   localparam int PW   = $clog2(DEPTH);
   localparam int CNTW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [CNTW-1:0]  count_ff, count_in;

   // Advance pointers and occupancy
   always_comb begin
      rd_ptr_in = rd_ptr_ff + PW'(pop);
      wr_ptr_in = wr_ptr_ff + PW'(push0) + PW'(push1);
      count_in  = count_ff + CNTW'(push0) + CNTW'(push1) - CNTW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= '0;
         wr_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store incoming beats; the second one lands behind the first
   always_ff @(posedge clock) begin
      if (push0) begin
         slot_ff[wr_ptr_ff] <= data0;
      end
      if (push1) begin
         slot_ff[wr_ptr_ff + PW'(1)] <= data1;
      end
   end

   assign head  = slot_ff[rd_ptr_ff];
   assign empty = (count_ff == '0);
   assign count = count_ff;

endmodule

// ===== design/jss_front.sv =====
// Front end: row and column tracking and classification of each input cell.
// Uses jss_pkg for the command type and field widths.
module jss_front #(
   parameter int MAX_WIDTH  = 512,
   parameter int MAX_HEIGHT = 512
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         accept,
   input  jss_pkg::value_type           cell_value,
   input  logic [jss_pkg::DIM_W-1:0]    grid_width,
   input  logic [jss_pkg::DIM_W-1:0]    grid_height,
   output jss_pkg::cmd_type             cmd,
   output logic [$clog2(MAX_WIDTH)-1:0] col
);

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int RW = $clog2(MAX_HEIGHT);

   logic [CW-1:0] col_ff, col_in;
   logic [RW-1:0] row_ff, row_in;
   logic [CW-1:0] ew_m1;
   logic [RW-1:0] eh_m1;
   logic [CW-1:0] c;
   logic [RW-1:0] r;
   logic          row_end;
   logic          last_row;

   // Clamp the dimensions to [3, max] and keep the last index
   always_comb begin
      if (grid_width < jss_pkg::DIM_W'(3)) begin
         ew_m1 = CW'(2);
      end else if (32'(grid_width) > 32'(MAX_WIDTH)) begin
         ew_m1 = CW'(MAX_WIDTH - 1);
      end else begin
         ew_m1 = CW'(grid_width - jss_pkg::DIM_W'(1));
      end
      if (grid_height < jss_pkg::DIM_W'(3)) begin
         eh_m1 = RW'(2);
      end else if (32'(grid_height) > 32'(MAX_HEIGHT)) begin
         eh_m1 = RW'(MAX_HEIGHT - 1);
      end else begin
         eh_m1 = RW'(grid_height - jss_pkg::DIM_W'(1));
      end
   end

   // Position of this cell; a counter past a shrunk edge sits on the edge
   always_comb begin
      c        = (col_ff < ew_m1) ? col_ff : ew_m1;
      r        = (row_ff < eh_m1) ? row_ff : eh_m1;
      row_end  = (c == ew_m1);
      last_row = (r == eh_m1);
   end

   // Classify the output cell one row up
   always_comb begin
      cmd.value     = cell_value;
      cmd.emit      = (r != '0);
      cmd.interior  = (r > RW'(1)) && (c != '0) && (c != ew_m1);
      cmd.second    = last_row && (r != '0);
      cmd.frame_end = last_row && row_end;
      col           = c;
   end

   // Advance the raster position
   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (row_end) begin
            col_in = '0;
            row_in = last_row ? '0 : r + RW'(1);
         end else begin
            col_in = c + CW'(1);
            row_in = r;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

endmodule

// ===== design/jss_back.sv =====
// Back end: row stores, five-point stencil, running maximum of the change.
// Uses jss_pkg types and jss_ram for the two row stores (one 2x wide word).
module jss_back #(
   parameter int MAX_WIDTH = 512,
   parameter int RSP_DEPTH = 4
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             cmd_empty,
   input  jss_pkg::cmd_type                 cmd_head,
   input  logic [$clog2(MAX_WIDTH)-1:0]     cmd_col,
   output logic                             cmd_pop,
   input  logic [$clog2(RSP_DEPTH+1)-1:0]   rsp_count,
   input  jss_pkg::value_type               threshold,
   output logic                             rsp_push0,
   output logic                             rsp_push1,
   output jss_pkg::rsp_type                 rsp_data0,
   output jss_pkg::rsp_type                 rsp_data1
);

   localparam int CW   = $clog2(MAX_WIDTH);
   localparam int CNTW = $clog2(RSP_DEPTH + 1);
   localparam int V    = jss_pkg::VALUE_W;

   // Read stage
   logic            issue;
   logic [CNTW:0]   rsp_need;
   logic [1:0]      m_pushes;

   // Compute stage
   logic                    m_valid_ff, m_valid_in;
   jss_pkg::cmd_type        m_cmd_ff;
   logic [CW-1:0]           m_col_ff;
   logic [CW-1:0]           m_col_next;

   // Last write, for reads issued in the same cycle
   logic                         lw_valid_ff, lw_valid_in;
   logic [CW-1:0]                lw_addr_ff;
   logic [jss_pkg::WORD_W-1:0]   lw_data_ff;

   logic [jss_pkg::WORD_W-1:0]   rd_word_a, rd_word_b;
   logic [jss_pkg::WORD_W-1:0]   word_c, word_r;
   logic [jss_pkg::WORD_W-1:0]   wr_word;

   jss_pkg::value_type   up, center, right, down;
   jss_pkg::value_type   left_ff, left_in;
   jss_pkg::value_type   run_ff, run_in;
   logic [jss_pkg::SUM_W-1:0] sum;
   jss_pkg::value_type   nv, delta, mx;

   // Row stores: upper half holds the older row, lower half the newer row
   jss_ram #(
      .WIDTH (jss_pkg::WORD_W),
      .DEPTH (MAX_WIDTH)
   ) u_row_ram (
      .clock     (clock),
      .wr_en     (m_valid_ff),
      .wr_addr   (m_col_ff),
      .wr_data   (wr_word),
      .rd_addr_a (cmd_col),
      .rd_addr_b (cmd_col + CW'(1)),
      .rd_data_a (rd_word_a),
      .rd_data_b (rd_word_b)
   );

   // Issue only with room for two more results after this cycle's pushes
   always_comb begin
      m_pushes = 2'(rsp_push0) + 2'(rsp_push1);
      rsp_need = {1'b0, rsp_count} + (CNTW + 1)'(m_pushes);
      issue    = !cmd_empty && (rsp_need <= (CNTW + 1)'(RSP_DEPTH - 2));
      cmd_pop  = issue;
      m_valid_in = issue;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m_valid_ff  <= 1'b0;
         lw_valid_ff <= 1'b0;
         run_ff      <= '0;
      end else begin
         m_valid_ff  <= m_valid_in;
         lw_valid_ff <= lw_valid_in;
         run_ff      <= run_in;
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         m_cmd_ff <= cmd_head;
         m_col_ff <= cmd_col;
      end
      lw_addr_ff <= m_col_ff;
      lw_data_ff <= wr_word;
      left_ff    <= left_in;
   end

   // Pick up the word written in the read cycle, else the RAM data
   always_comb begin
      m_col_next = m_col_ff + CW'(1);
      word_c = (lw_valid_ff && (lw_addr_ff == m_col_ff))   ? lw_data_ff : rd_word_a;
      word_r = (lw_valid_ff && (lw_addr_ff == m_col_next)) ? lw_data_ff : rd_word_b;
      up     = word_c[2*V-1:V];
      center = word_c[V-1:0];
      right  = word_r[V-1:0];
      down   = m_cmd_ff.value;
      // shift the column: newer row moves up, the input cell comes in
      wr_word     = {center, down};
      lw_valid_in = m_valid_ff;
      // the left neighbor is the center of the previous cell
      left_in     = m_valid_ff ? center : left_ff;
   end

   // Stencil and change tracking; only interior cells count toward the change
   always_comb begin
      sum = jss_pkg::SUM_W'(up) + jss_pkg::SUM_W'(down)
          + jss_pkg::SUM_W'(left_ff) + jss_pkg::SUM_W'(right);
      nv    = m_cmd_ff.interior ? sum[jss_pkg::SUM_W-1:2] : center;
      delta = (nv >= center) ? nv - center : center - nv;
      mx    = (m_cmd_ff.interior && (delta > run_ff)) ? delta : run_ff;
      run_in = run_ff;
      if (m_valid_ff) begin
         run_in = m_cmd_ff.frame_end ? '0 : mx;
      end
   end

   // Results: the stencil cell, then on the last row the input cell itself
   always_comb begin
      rsp_push0 = m_valid_ff && m_cmd_ff.emit;
      rsp_push1 = m_valid_ff && m_cmd_ff.second;

      rsp_data0.new_value  = nv;
      rsp_data0.frame_last = 1'b0;
      rsp_data0.max_change = '0;
      rsp_data0.converged  = 1'b0;

      rsp_data1.new_value  = down;
      rsp_data1.frame_last = m_cmd_ff.frame_end;
      rsp_data1.max_change = m_cmd_ff.frame_end ? mx : '0;
      rsp_data1.converged  = m_cmd_ff.frame_end && (mx < threshold);
   end

endmodule

// ===== design/jacobi_stencil_sweep_unit.sv =====
// Top level of the Jacobi stencil sweep unit: csr registers, front, back, queues.
// Depends on jss_pkg, jss_front, jss_back, jss_fifo and jss_ram.
//
// One Jacobi sweep of a grid of unsigned Q8.16 cells, streamed in raster order.
// The unit takes one cell per cycle while req_full is low; for input cell (r,c)
// it returns the new value of cell (r-1,c), interior cells as the truncated
// mean of their four neighbors and edge cells unchanged. Cells of row 0 give
// no result; every cell of the last row gives two, the cell above and then the
// cell itself, so the last two rows come out interleaved and that row is held
// to the result port's one beat per cycle. The last result of a sweep carries
// frame_last, the largest interior change and the converged flag (change below
// csr threshold). A cell passes the command queue and the compute stage
// register; the row stores are one dual-read RAM of MAX_WIDTH words and need no
// clearing after reset. Write the csr registers only while the unit is drained.
module jacobi_stencil_sweep_unit #(
   parameter int MAX_WIDTH  = 512,
   parameter int MAX_HEIGHT = 512
) (
   input  logic                              clock,
   input  logic                              reset,
   // input cells
   input  logic                              req_push,
   output logic                              req_full,
   input  logic [jss_pkg::VALUE_W-1:0]       req_cell_value,
   // results
   output logic                              rsp_empty,
   input  logic                              rsp_pop,
   output logic [jss_pkg::VALUE_W-1:0]       rsp_new_value,
   output logic                              rsp_frame_last,
   output logic [jss_pkg::VALUE_W-1:0]       rsp_max_change,
   output logic                              rsp_converged,
   // register writes
   input  logic                              csr_write,
   input  logic [jss_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [jss_pkg::CSR_DATA_W-1:0]    csr_data
);

   localparam int CW        = $clog2(MAX_WIDTH);
   localparam int CMD_DEPTH = 4;
   localparam int RSP_DEPTH = 4;
   localparam int CMD_W     = $bits(jss_pkg::cmd_type) + CW;
   localparam int RSP_W     = $bits(jss_pkg::rsp_type);
   localparam int CMD_CNTW  = $clog2(CMD_DEPTH + 1);
   localparam int RSP_CNTW  = $clog2(RSP_DEPTH + 1);

   logic [jss_pkg::DIM_W-1:0] grid_width_ff, grid_width_in;
   logic [jss_pkg::DIM_W-1:0] grid_height_ff, grid_height_in;
   jss_pkg::value_type        threshold_ff, threshold_in;

   logic                  req_accept;
   jss_pkg::cmd_type      front_cmd;
   logic [CW-1:0]         front_col;
   logic [CMD_W-1:0]      cmd_head_word;
   logic                  cmd_empty;
   logic                  cmd_pop;
   logic [CMD_CNTW-1:0]   cmd_count;
   jss_pkg::cmd_type      cmd_head;
   logic [CW-1:0]         cmd_col;

   logic                  rsp_push0, rsp_push1;
   jss_pkg::rsp_type      rsp_data0, rsp_data1;
   jss_pkg::rsp_type      rsp_head;
   logic [RSP_CNTW-1:0]   rsp_count;
   logic                  rsp_accept;

   // Decode register writes
   always_comb begin
      grid_width_in  = grid_width_ff;
      grid_height_in = grid_height_ff;
      threshold_in   = threshold_ff;
      if (csr_write) begin
         unique case (csr_index)
            jss_pkg::CSR_GRID_WIDTH: begin
               grid_width_in = csr_data[jss_pkg::DIM_W-1:0];
            end
            jss_pkg::CSR_GRID_HEIGHT: begin
               grid_height_in = csr_data[jss_pkg::DIM_W-1:0];
            end
            jss_pkg::CSR_CHANGE_THRESHOLD: begin
               threshold_in = csr_data[jss_pkg::VALUE_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_width_ff  <= jss_pkg::RESET_GRID_WIDTH;
         grid_height_ff <= jss_pkg::RESET_GRID_HEIGHT;
         threshold_ff   <= jss_pkg::RESET_CHANGE_THRESHOLD;
      end else begin
         grid_width_ff  <= grid_width_in;
         grid_height_ff <= grid_height_in;
         threshold_ff   <= threshold_in;
      end
   end

   // Front: accept and classify cells
   assign req_full   = (cmd_count == CMD_CNTW'(CMD_DEPTH));
   assign req_accept = req_push && !req_full;

   jss_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .accept      (req_accept),
      .cell_value  (req_cell_value),
      .grid_width  (grid_width_ff),
      .grid_height (grid_height_ff),
      .cmd         (front_cmd),
      .col         (front_col)
   );

   // Command queue between front and back
   jss_fifo #(
      .WIDTH (CMD_W),
      .DEPTH (CMD_DEPTH)
   ) u_cmd_fifo (
      .clock (clock),
      .reset (reset),
      .push0 (req_accept),
      .push1 (1'b0),
      .data0 ({front_cmd, front_col}),
      .data1 ('0),
      .pop   (cmd_pop),
      .head  (cmd_head_word),
      .empty (cmd_empty),
      .count (cmd_count)
   );

   assign cmd_head = jss_pkg::cmd_type'(cmd_head_word[CMD_W-1:CW]);
   assign cmd_col  = cmd_head_word[CW-1:0];

   // Back: stencil over the row stores
   jss_back #(
      .MAX_WIDTH (MAX_WIDTH),
      .RSP_DEPTH (RSP_DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_empty (cmd_empty),
      .cmd_head  (cmd_head),
      .cmd_col   (cmd_col),
      .cmd_pop   (cmd_pop),
      .rsp_count (rsp_count),
      .threshold (threshold_ff),
      .rsp_push0 (rsp_push0),
      .rsp_push1 (rsp_push1),
      .rsp_data0 (rsp_data0),
      .rsp_data1 (rsp_data1)
   );

   // Result queue
   assign rsp_accept = rsp_pop && !rsp_empty;

   jss_fifo #(
      .WIDTH (RSP_W),
      .DEPTH (RSP_DEPTH)
   ) u_rsp_fifo (
      .clock (clock),
      .reset (reset),
      .push0 (rsp_push0),
      .push1 (rsp_push1),
      .data0 (rsp_data0),
      .data1 (rsp_data1),
      .pop   (rsp_accept),
      .head  (rsp_head),
      .empty (rsp_empty),
      .count (rsp_count)
   );

   assign rsp_new_value  = rsp_head.new_value;
   assign rsp_frame_last = rsp_head.frame_last;
   assign rsp_max_change = rsp_head.max_change;
   assign rsp_converged  = rsp_head.converged;

   // The back end's credit check keeps the result queue from overflowing
   a_rsp_no_overflow: assert property (@(posedge clock) disable iff (reset)
      rsp_count <= RSP_CNTW'(RSP_DEPTH))
      else $error("result queue overflow");

   // A second push only ever follows a first push
   a_push_order: assert property (@(posedge clock) disable iff (reset)
      rsp_push1 |-> rsp_push0)
      else $error("second result without first");

   // Only the final result of a sweep carries the change summary
   a_summary_last: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_frame_last) |-> (rsp_max_change == '0 && !rsp_converged))
      else $error("change summary on a non-final result");

   // An accepted cell is waiting in the command queue on the next cycle
   a_cmd_capture: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> !cmd_empty)
      else $error("accepted cell lost");

endmodule

// ===== tb/sv/jacobi_stencil_sweep_unit_test.sv =====
// Self-checking testbench for jacobi_stencil_sweep_unit: directed plan, then random sweeps.
// Depends on jss_pkg and the unit's RTL; a built-in sweep predictor checks every result beat.
module jacobi_stencil_sweep_unit_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned        MAX_W       = 512;
   localparam int unsigned        MAX_H       = 512;
   localparam int                 PAUSE       = 8;
   localparam int                 TAIL        = 40;
   localparam int                 CYCLE_LIMIT = 600000;
   localparam int                 PLAN_LEN    = 27;
   localparam int                 PHASE_CELLS = 110;
   localparam jss_pkg::value_type CELL_MAX    = '1;

   typedef enum logic [1:0] {PLAN_CSR, PLAN_CELL, PLAN_TYPED} plan_kind_type;
   typedef enum logic [1:0] {FILL_NOISE, FILL_FLAT, FILL_RIPPLE, FILL_EXTREME} fill_type;

   // One row of the directed plan: a register write, or a cell with optional typed results
   typedef struct packed {
      plan_kind_type                  kind;
      logic [jss_pkg::CSR_IDX_W-1:0]  index;
      logic [jss_pkg::CSR_DATA_W-1:0] data;
      logic [1:0]                     n_out;
      jss_pkg::rsp_type               out0;
      jss_pkg::rsp_type               out1;
   } plan_row_type;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_push = 1'b0;
   logic                           req_full;
   logic [jss_pkg::VALUE_W-1:0]    req_cell_value = '0;
   logic                           rsp_empty;
   logic                           rsp_pop = 1'b0;
   logic [jss_pkg::VALUE_W-1:0]    rsp_new_value;
   logic                           rsp_frame_last;
   logic [jss_pkg::VALUE_W-1:0]    rsp_max_change;
   logic                           rsp_converged;
   logic                           csr_write = 1'b0;
   logic [jss_pkg::CSR_IDX_W-1:0]  csr_index = '0;
   logic [jss_pkg::CSR_DATA_W-1:0] csr_data = '0;

   // Predictor state: registers, the two row stores, sweep position
   logic [jss_pkg::DIM_W-1:0] grid_w      = jss_pkg::RESET_GRID_WIDTH;
   logic [jss_pkg::DIM_W-1:0] grid_h      = jss_pkg::RESET_GRID_HEIGHT;
   jss_pkg::value_type        tolerance   = jss_pkg::RESET_CHANGE_THRESHOLD;
   jss_pkg::value_type        row_n1 [MAX_W];
   jss_pkg::value_type        row_n2 [MAX_W];
   int unsigned               row_pos     = 0;
   int unsigned               col_pos     = 0;
   jss_pkg::value_type        worst_delta = '0;
   bit                        sweep_closed = 1'b0;

   jss_pkg::rsp_type due_results [$];
   int               mismatches     = 0;
   int               cells_sent     = 0;
   int               cycle_count    = 0;
   int               send_idle_pct  = 0;
   int               recv_stall_pct = 0;
   int               hold_left      = 0;
   plan_row_type     plan [PLAN_LEN];

   int SEND_IDLE  [4] = '{0, 70, 0, 17};
   int RECV_STALL [4] = '{0, 0, 70, 17};

   jacobi_stencil_sweep_unit u_top (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_cell_value (req_cell_value),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_new_value  (rsp_new_value),
      .rsp_frame_last (rsp_frame_last),
      .rsp_max_change (rsp_max_change),
      .rsp_converged  (rsp_converged),
      .csr_write      (csr_write),
      .csr_index      (csr_index),
      .csr_data       (csr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Advance the sweep by one input cell; return how many result beats it yields
   function automatic int jacobi_step(input jss_pkg::value_type x,
                                      output jss_pkg::rsp_type first,
                                      output jss_pkg::rsp_type second);
      int unsigned               ew, eh, r, c;
      jss_pkg::value_type        up, center, right, left, nv, delta;
      logic [jss_pkg::SUM_W-1:0] sum;
      logic                      row_end, bottom, interior;
      int                        n;
      first  = '0;
      second = '0;
      n      = 0;
      ew = (grid_w < 3) ? 3 : ((grid_w > MAX_W) ? MAX_W : grid_w);
      eh = (grid_h < 3) ? 3 : ((grid_h > MAX_H) ? MAX_H : grid_h);
      r  = (row_pos < eh - 1) ? row_pos : eh - 1;
      c  = (col_pos < ew - 1) ? col_pos : ew - 1;
      row_end = (c == ew - 1);
      bottom  = (r == eh - 1);

      // Read neighbors, then shift this column down one row
      up     = row_n2[c];
      center = row_n1[c];
      right  = (c + 1 < MAX_W) ? row_n1[c + 1] : '0;
      row_n2[c] = center;
      row_n1[c] = x;
      left   = (c >= 1) ? row_n2[c - 1] : '0;

      if (r >= 1) begin
         interior = (r - 1 >= 1) && (c >= 1) && (c < ew - 1);
         nv = center;
         if (interior) begin
            sum   = jss_pkg::SUM_W'(up) + jss_pkg::SUM_W'(x)
                  + jss_pkg::SUM_W'(left) + jss_pkg::SUM_W'(right);
            nv    = sum[jss_pkg::SUM_W-1:2];
            delta = (nv >= center) ? nv - center : center - nv;
            if (delta > worst_delta) worst_delta = delta;
         end
         first = '{new_value: nv, frame_last: 1'b0, max_change: '0, converged: 1'b0};
         n = 1;
         if (bottom) begin
            second = '{new_value: x, frame_last: row_end,
                       max_change: row_end ? worst_delta : '0,
                       converged: row_end && (worst_delta < tolerance)};
            n = 2;
         end
      end

      // Move the raster position; wrap at the end of the sweep
      if (row_end) begin
         col_pos = 0;
         if (bottom) begin
            row_pos      = 0;
            worst_delta  = '0;
            sweep_closed = 1'b1;
         end else begin
            row_pos = r + 1;
         end
      end else begin
         col_pos = c + 1;
         row_pos = r;
      end
      return n;
   endfunction

   function automatic jss_pkg::rsp_type cell_beat(input jss_pkg::value_type v,
                                                  input logic last,
                                                  input jss_pkg::value_type mx,
                                                  input logic conv);
      return '{new_value: v, frame_last: last, max_change: mx, converged: conv};
   endfunction

   function automatic plan_row_type csr_row(input logic [jss_pkg::CSR_IDX_W-1:0] idx,
                                            input logic [jss_pkg::CSR_DATA_W-1:0] d);
      return '{kind: PLAN_CSR, index: idx, data: d, n_out: 2'd0, out0: '0, out1: '0};
   endfunction

   function automatic plan_row_type cell_row(input jss_pkg::value_type v);
      return '{kind: PLAN_CELL, index: '0, data: v, n_out: 2'd0, out0: '0, out1: '0};
   endfunction

   function automatic plan_row_type typed_row(input jss_pkg::value_type v,
                                              input logic [1:0] n,
                                              input jss_pkg::rsp_type o0,
                                              input jss_pkg::rsp_type o1);
      return '{kind: PLAN_TYPED, index: '0, data: v, n_out: n, out0: o0, out1: o1};
   endfunction

   function automatic jss_pkg::value_type next_cell(input fill_type fill,
                                                    input jss_pkg::value_type base);
      case (fill)
         FILL_NOISE:  return jss_pkg::value_type'($urandom);
         FILL_FLAT:   return base;
         FILL_RIPPLE: return base + jss_pkg::value_type'($urandom_range(0, 3));
         default:     return $urandom_range(0, 1) ? CELL_MAX : '0;
      endcase
   endfunction

   // Offer one cell beat until accepted, then book its expected results
   task automatic send_cell(input jss_pkg::value_type v, input bit typed = 1'b0,
                            input logic [1:0] n_typed = 2'd0,
                            input jss_pkg::rsp_type t0 = '0,
                            input jss_pkg::rsp_type t1 = '0);
      jss_pkg::rsp_type r0, r1;
      int               n;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         @(negedge clock);
         req_push = 1'b0;
      end
      @(negedge clock);
      req_push       = 1'b1;
      req_cell_value = v;
      do @(posedge clock); while (req_full);
      n = jacobi_step(v, r0, r1);
      if (typed) begin
         n  = n_typed;
         r0 = t0;
         r1 = t1;
      end
      if (n > 0) due_results.push_back(r0);
      if (n > 1) due_results.push_back(r1);
      cells_sent++;
   endtask

   // Drop push, wait for every booked result, then let the pipeline empty
   task automatic settle();
      @(negedge clock);
      req_push = 1'b0;
      while (due_results.size() != 0) @(posedge clock);
      repeat (PAUSE) @(posedge clock);
   endtask

   task automatic write_csr(input logic [jss_pkg::CSR_IDX_W-1:0] idx,
                            input logic [jss_pkg::CSR_DATA_W-1:0] d);
      @(negedge clock);
      csr_write = 1'b1;
      csr_index = idx;
      csr_data  = d;
      case (idx)
         jss_pkg::CSR_GRID_WIDTH:       grid_w    = d[jss_pkg::DIM_W-1:0];
         jss_pkg::CSR_GRID_HEIGHT:      grid_h    = d[jss_pkg::DIM_W-1:0];
         jss_pkg::CSR_CHANGE_THRESHOLD: tolerance = d[jss_pkg::VALUE_W-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_write = 1'b0;
   endtask

   // One full sweep with fresh registers; optionally cut the height while mid-sweep
   task automatic run_sweep(input logic [jss_pkg::DIM_W-1:0] w_reg,
                            input logic [jss_pkg::DIM_W-1:0] h_reg,
                            input bit may_split, input int hold);
      int unsigned        ew, eh, rows_in, cut_col;
      fill_type           fill;
      jss_pkg::value_type base, limit;
      settle();
      case ($urandom_range(0, 3))
         0:       limit = '0;
         1:       limit = '1;
         2:       limit = jss_pkg::value_type'($urandom_range(0, 8));
         default: limit = jss_pkg::value_type'($urandom);
      endcase
      write_csr(jss_pkg::CSR_GRID_WIDTH, jss_pkg::CSR_DATA_W'(w_reg));
      write_csr(jss_pkg::CSR_GRID_HEIGHT, jss_pkg::CSR_DATA_W'(h_reg));
      write_csr(jss_pkg::CSR_CHANGE_THRESHOLD, limit);
      sweep_closed = 1'b0;
      fill = fill_type'($urandom_range(0, 3));
      base = jss_pkg::value_type'($urandom_range(0, 24'hFFFFF0));
      ew = (w_reg < 3) ? 3 : ((w_reg > MAX_W) ? MAX_W : w_reg);
      eh = (h_reg < 3) ? 3 : ((h_reg > MAX_H) ? MAX_H : h_reg);
      if (hold > 0) begin
         @(posedge clock);
         hold_left = hold;
      end
      if (may_split && eh >= 5 && $urandom_range(0, 2) == 0) begin
         rows_in = $urandom_range(3, eh - 2);
         cut_col = $urandom_range(0, ew - 1);
         repeat (rows_in * ew + cut_col) send_cell(next_cell(fill, base));
         settle();
         write_csr(jss_pkg::CSR_GRID_HEIGHT,
                   jss_pkg::CSR_DATA_W'($urandom_range(3, rows_in)));
      end
      while (!sweep_closed) send_cell(next_cell(fill, base));
   endtask

   // Result side: pop at random, compare each beat with the oldest booking
   always begin : result_sink
      jss_pkg::rsp_type got, want;
      @(negedge clock);
      if (hold_left > 0) begin
         rsp_pop   = 1'b0;
         hold_left = hold_left - 1;
      end else begin
         rsp_pop = !reset && ($urandom_range(0, 99) >= recv_stall_pct);
      end
      @(posedge clock);
      if (rsp_pop && !rsp_empty) begin
         got = '{new_value: rsp_new_value, frame_last: rsp_frame_last,
                 max_change: rsp_max_change, converged: rsp_converged};
         if (due_results.size() == 0) begin
            $error("result beat with nothing booked: new_value %h", got.new_value);
            mismatches++;
         end else begin
            want = due_results.pop_front();
            if (got.new_value !== want.new_value) begin
               $error("new_value: expected %h, actual %h", want.new_value, got.new_value);
               mismatches++;
            end
            if (got.frame_last !== want.frame_last) begin
               $error("frame_last: expected %b, actual %b", want.frame_last, got.frame_last);
               mismatches++;
            end
            if (got.max_change !== want.max_change) begin
               $error("max_change: expected %h, actual %h", want.max_change, got.max_change);
               mismatches++;
            end
            if (got.converged !== want.converged) begin
               $error("converged: expected %b, actual %b", want.converged, got.converged);
               mismatches++;
            end
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   initial begin
      int phase_start;
      // Reset-value row of 500 cells cut short by a width change, then a height cut,
      // then a 3x3 sweep with a cold center under the widest tolerance
      plan = '{
         cell_row(24'h000000), cell_row(24'hFFFFFF), cell_row(24'h000001),
         cell_row(24'h800000), cell_row(24'h7FFFFF),
         csr_row(jss_pkg::CSR_GRID_WIDTH, 24'd3),
         cell_row(24'h00FFFF),
         cell_row(24'h123456), cell_row(24'hFEDCBA), cell_row(24'h010101),
         cell_row(24'hAAAAAA), cell_row(24'h555555), cell_row(24'hFFFFFE),
         csr_row(jss_pkg::CSR_GRID_HEIGHT, 24'd3),
         cell_row(24'h000002), cell_row(24'hC0FFEE), cell_row(24'h0F0F0F),
         csr_row(jss_pkg::CSR_CHANGE_THRESHOLD, 24'hFFFFFF),
         typed_row('0, 2'd0, '0, '0),
         typed_row(CELL_MAX, 2'd0, '0, '0),
         typed_row('0, 2'd0, '0, '0),
         typed_row(CELL_MAX, 2'd1, cell_beat('0, 1'b0, '0, 1'b0), '0),
         typed_row('0, 2'd1, cell_beat(CELL_MAX, 1'b0, '0, 1'b0), '0),
         typed_row(CELL_MAX, 2'd1, cell_beat('0, 1'b0, '0, 1'b0), '0),
         typed_row('0, 2'd2, cell_beat(CELL_MAX, 1'b0, '0, 1'b0),
                   cell_beat('0, 1'b0, '0, 1'b0)),
         typed_row(CELL_MAX, 2'd2, cell_beat(CELL_MAX, 1'b0, '0, 1'b0),
                   cell_beat(CELL_MAX, 1'b0, '0, 1'b0)),
         typed_row('0, 2'd2, cell_beat(CELL_MAX, 1'b0, '0, 1'b0),
                   cell_beat('0, 1'b1, CELL_MAX, 1'b0))
      };

      // Hold reset, release on a falling edge
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed plan
      foreach (plan[i]) begin
         if (plan[i].kind == PLAN_CSR) begin
            settle();
            write_csr(plan[i].index, plan[i].data);
         end else begin
            send_cell(plan[i].data, plan[i].kind == PLAN_TYPED, plan[i].n_out,
                      plan[i].out0, plan[i].out1);
         end
      end

      // Random sweeps, one idling mode per phase
      for (int p = 0; p < 4; p++) begin
         settle();
         send_idle_pct  = SEND_IDLE[p];
         recv_stall_pct = RECV_STALL[p];
         phase_start    = cells_sent;
         if (p == 0) begin
            run_sweep(10'd20, 10'd6, 1'b0, 400);
            run_sweep(10'd2, 10'd0, 1'b0, 0);
         end
         while (cells_sent - phase_start < PHASE_CELLS) begin
            run_sweep(($urandom_range(0, 9) == 0) ? jss_pkg::DIM_W'($urandom_range(0, 2))
                                                  : jss_pkg::DIM_W'($urandom_range(3, 14)),
                      ($urandom_range(0, 9) == 0) ? jss_pkg::DIM_W'($urandom_range(0, 2))
                                                  : jss_pkg::DIM_W'($urandom_range(3, 10)),
                      1'b1, 0);
         end
      end

      // Drain and watch for stray beats
      settle();
      repeat (TAIL) @(posedge clock);
      if (mismatches == 0 && due_results.size() == 0) begin
         $display("== PASS ==");
      end else begin
         if (due_results.size() != 0)
            $error("%0d booked results never arrived", due_results.size());
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
